### src/bsp_pkg.sv
`timescale 1ns / 1ps

package bsp_pkg;

	localparam int WORD_W = 32;

	// Opcodes of an input item
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_DISPLAY = 2'd2;
	localparam logic [1:0] OP_PAL     = 2'd3;

	// Status codes of a result item
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data_word;
		logic                     is_palindrome;
		logic                     last_result;
	} rsp_t;

endpackage

### src/bsp_stream_if.sv
`timescale 1ns / 1ps

interface bsp_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/bounded_stack_with_palindrome.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words, STACK_DEPTH entries deep.
// req carries one item per command: opcode and push_value. rsp returns
// result items: status, data_word, is_palindrome and last_result, which
// marks the final result of a command.
// Push finishes at the accepting edge: its result is shown the next cycle.
// Pop reads the top entry through the registered memory port in S_POP_RD
// and loads its result into the output register from S_POP_EMIT.
// Display gives one result per stored word, bottom first, each word read
// through the registered memory port in S_DISP_RD and sent from S_DISP_EMIT.
// Palindrome reads a pair of entries from both ends at a time and
// compares them in one comparator: up to count/2 pairs, stopping at the
// first mismatch. Commands on an empty stack answer the next cycle.
// req.ready is high only while no command is in progress and the output
// register is free or being taken, so one command is handled at a time.
// A stalled rsp holds its item; the block waits without losing it.
// Reset empties the stack and drops any pending result; the memory
// contents need no clearing.
module bounded_stack_with_palindrome #(
	parameter int STACK_DEPTH = 8
) (
	input logic         clk,
	input logic         arst_n,
	bsp_stream_if.sink   req,
	bsp_stream_if.source rsp
);

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_POP_RD    = 3'd1;
	localparam logic [2:0] S_POP_EMIT  = 3'd2;
	localparam logic [2:0] S_DISP_RD   = 3'd3;
	localparam logic [2:0] S_DISP_EMIT = 3'd4;
	localparam logic [2:0] S_PAL_RD    = 3'd5;
	localparam logic [2:0] S_PAL_CMP   = 3'd6;

	logic [2:0]       state_q, nxt_state;
	logic [CNT_W-1:0] count_q, nxt_count;
	logic [IDX_W-1:0] lo_q, nxt_lo;
	logic [IDX_W-1:0] hi_q, nxt_hi;
	logic             out_valid_q;
	bsp_pkg::rsp_t    out_q, nxt_out;
	logic             load_out;

	logic             slot_free;
	logic             acc;
	logic             empty;
	logic             full;
	logic [IDX_W-1:0] top_idx;
	logic             pal_done;

	logic                       mem_we;
	logic                       mem_re;
	logic [bsp_pkg::WORD_W-1:0] rdata_a, rdata_b;

	// Handshake and stack flags
	always_comb begin
		slot_free = !out_valid_q || rsp.ready;
		req.ready = (state_q == S_IDLE) && slot_free;
		acc       = req.valid && req.ready;
		empty     = (count_q == '0);
		full      = (count_q == CNT_W'(STACK_DEPTH));
		top_idx   = IDX_W'(count_q - CNT_W'(1));
		pal_done  = ({1'b0, lo_q} + (IDX_W+1)'(1)) >= ({1'b0, hi_q} - (IDX_W+1)'(1));
	end

	assign mem_we = acc && (req.data.opcode == bsp_pkg::OP_PUSH) && !full;
	assign mem_re = (state_q == S_POP_RD) || (state_q == S_DISP_RD) || (state_q == S_PAL_RD);

	bsp_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (bsp_pkg::WORD_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (count_q[IDX_W-1:0]),
		.wdata   (req.data.push_value),
		.re      (mem_re),
		.raddr_a (lo_q),
		.raddr_b (hi_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Sequence the commands
	always_comb begin
		nxt_state = state_q;
		nxt_count = count_q;
		nxt_lo    = lo_q;
		nxt_hi    = hi_q;
		load_out  = 1'b0;
		nxt_out   = '0;
		nxt_out.last_result = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.data.opcode)
						bsp_pkg::OP_PUSH: begin
							load_out = 1'b1;
							if (full) begin
								nxt_out.status = bsp_pkg::ST_OVERFLOW;
							end else begin
								nxt_out.status    = bsp_pkg::ST_OK;
								nxt_out.data_word = req.data.push_value;
								nxt_count         = count_q + CNT_W'(1);
							end
						end
						bsp_pkg::OP_POP: begin
							if (empty) begin
								load_out       = 1'b1;
								nxt_out.status = bsp_pkg::ST_EMPTY;
							end else begin
								nxt_lo    = top_idx;
								nxt_count = count_q - CNT_W'(1);
								nxt_state = S_POP_RD;
							end
						end
						bsp_pkg::OP_DISPLAY: begin
							if (empty) begin
								load_out       = 1'b1;
								nxt_out.status = bsp_pkg::ST_EMPTY;
							end else begin
								nxt_lo    = '0;
								nxt_state = S_DISP_RD;
							end
						end
						default: begin
							if (empty) begin
								load_out       = 1'b1;
								nxt_out.status = bsp_pkg::ST_EMPTY;
							end else if (count_q == CNT_W'(1)) begin
								load_out              = 1'b1;
								nxt_out.is_palindrome = 1'b1;
							end else begin
								nxt_lo    = '0;
								nxt_hi    = top_idx;
								nxt_state = S_PAL_RD;
							end
						end
					endcase
				end
			end
			S_POP_RD: begin
				nxt_state = S_POP_EMIT;
			end
			S_POP_EMIT: begin
				if (slot_free) begin
					load_out          = 1'b1;
					nxt_out.data_word = rdata_a;
					nxt_state         = S_IDLE;
				end
			end
			S_DISP_RD: begin
				nxt_state = S_DISP_EMIT;
			end
			S_DISP_EMIT: begin
				if (slot_free) begin
					load_out            = 1'b1;
					nxt_out.data_word   = rdata_a;
					nxt_out.last_result = (lo_q == top_idx);
					if (lo_q == top_idx) begin
						nxt_state = S_IDLE;
					end else begin
						nxt_lo    = lo_q + IDX_W'(1);
						nxt_state = S_DISP_RD;
					end
				end
			end
			S_PAL_RD: begin
				nxt_state = S_PAL_CMP;
			end
			S_PAL_CMP: begin
				// Answer on a mismatch or once the ends meet, else advance both ends
				if (rdata_a != rdata_b || pal_done) begin
					if (slot_free) begin
						load_out              = 1'b1;
						nxt_out.is_palindrome = (rdata_a == rdata_b);
						nxt_state             = S_IDLE;
					end
				end else begin
					nxt_lo    = lo_q + IDX_W'(1);
					nxt_hi    = hi_q - IDX_W'(1);
					nxt_state = S_PAL_RD;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			count_q <= nxt_count;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Indices and output payload
	always_ff @(posedge clk) begin
		lo_q <= nxt_lo;
		hi_q <= nxt_hi;
		if (load_out) begin
			out_q <= nxt_out;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

### src/bsp_stack_mem.sv
`timescale 1ns / 1ps

module bsp_stack_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read two entries, hold the data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### src/bsp_checker.sv
`timescale 1ns / 1ps

module bsp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [1:0]                 rsp_status,
	input logic [bsp_pkg::WORD_W-1:0] rsp_data_word,
	input logic                       rsp_is_palindrome,
	input logic                       rsp_last_result
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_data_word) && $stable(rsp_last_result))
		else $error("stalled result item changed");

	// No new command while a display is still streaming
	a_busy_display: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last_result |-> !req_ready)
		else $error("input taken during a display");

	// Intermediate results are plain display words
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last_result |-> rsp_status == bsp_pkg::ST_OK && !rsp_is_palindrome)
		else $error("bad intermediate result item");

	// A palindrome answer is ok with no word
	a_pal_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_palindrome |->
			rsp_status == bsp_pkg::ST_OK && rsp_data_word == '0 && rsp_last_result)
		else $error("malformed palindrome answer");

	// Status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == bsp_pkg::ST_OK || rsp_status == bsp_pkg::ST_OVERFLOW
			|| rsp_status == bsp_pkg::ST_EMPTY)
		else $error("undefined status code");

endmodule

bind bounded_stack_with_palindrome bsp_checker u_bsp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.data.status),
	.rsp_data_word     (rsp.data.data_word),
	.rsp_is_palindrome (rsp.data.is_palindrome),
	.rsp_last_result   (rsp.data.last_result)
);
